[sv/wsi_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wsi_pkg
// Shared types and fixed-point constants for the Wilson score interval block.
// ----------------------------------------------------------------------------
package wsi_pkg;

	localparam int COUNT_BITS = 16;
	localparam int FRAC_BITS  = 16;
	localparam int GUARD      = 17;
	localparam int Z_BITS     = 16;
	localparam int OUT_BITS   = FRAC_BITS + 1;

	localparam int S_BITS     = 2 * Z_BITS;
	localparam int KK_BITS    = 2 * COUNT_BITS;
	localparam int P_BITS     = S_BITS + KK_BITS;
	localparam int CD_SHIFT   = 29;
	localparam int V_SHIFT    = 30;
	localparam int VNUM_BITS  = P_BITS + V_SHIFT;
	localparam int VQ_BITS    = 76;
	localparam int V_BITS     = VQ_BITS + 1;
	localparam int SQ_ARG_BITS = 112;
	localparam int W_BITS     = SQ_ARG_BITS / 2;
	localparam int CD_BITS    = 46;
	localparam int CG_BITS    = CD_BITS + GUARD;
	localparam int BNUM_BITS  = CG_BITS + 2;
	localparam int BDEN_BITS  = CD_BITS + 1;
	localparam int Q_BITS     = FRAC_BITS + 2;
	localparam int PNUM_BITS  = COUNT_BITS + FRAC_BITS + 2;
	localparam int PDEN_BITS  = COUNT_BITS + 1;
	localparam int FIFO_DEPTH = 4;

	localparam logic [Z_BITS-1:0]   Z_RESET = 16'd32113;
	localparam logic [S_BITS-1:0]   S_RESET = S_BITS'(64'(Z_RESET) * 64'(Z_RESET));
	localparam logic [OUT_BITS-1:0] ONE     = OUT_BITS'(1) << FRAC_BITS;

	typedef enum logic [1:0] {
		ERR_OK          = 2'd0,
		ERR_ZERO_TRIALS = 2'd1,
		ERR_EXCESS      = 2'd2
	} err_t;

	typedef struct packed {
		logic [15:0] successes;
		logic [15:0] trials;
	} item_t;

	typedef struct packed {
		logic [OUT_BITS-1:0] proportion;
		logic [OUT_BITS-1:0] lower_bound;
		logic [OUT_BITS-1:0] upper_bound;
		err_t                error_code;
	} result_t;

	typedef struct packed {
		logic [COUNT_BITS-1:0] k;
		logic [COUNT_BITS-1:0] n;
		err_t                  err;
	} entry_t;

endpackage
`default_nettype wire

[sv/wilson_score_interval.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wilson_score_interval
// Binomial proportion and Wilson score interval bounds in unsigned Q1.16.
// ----------------------------------------------------------------------------
// Takes one (successes, trials) pair per cycle while item_stall is low and
// returns one result per pair, in order: k/n and the clamped Wilson interval
// ends, each rounded to nearest. Zero trials or successes above trials give
// zero values with an error code. Throughput is one transaction per clock
// while result_stall is low. Each transaction passes the 76-stage divider
// for the variance term, the 56-stage square root and the 18-stage final
// dividers. A four-entry queue sits at the input, so the input side keeps
// taking transactions after the output stalls until the queue is full. z_score
// (Q2.14, reset 1.96) must only be written while no transaction is in flight.
module wilson_score_interval
	import wsi_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  item_t             item,
	output logic              result_valid,
	input  logic              result_stall,
	output result_t           result,
	input  logic              z_score_we,
	input  logic [Z_BITS-1:0] z_score_wdata
);
	logic [S_BITS-1:0] z_sq;
	logic              entry_valid;
	logic              entry_pop;
	entry_t            entry;

	wsi_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.item          (item),
		.z_score_we    (z_score_we),
		.z_score_wdata (z_score_wdata),
		.z_sq          (z_sq),
		.entry_valid   (entry_valid),
		.entry_pop     (entry_pop),
		.entry         (entry)
	);

	wsi_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.entry_valid  (entry_valid),
		.entry        (entry),
		.entry_pop    (entry_pop),
		.z_sq         (z_sq),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
`default_nettype wire

[sv/wsi_fifo.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wsi_fifo
// Small flop-based queue between the classifying front and the arithmetic back.
// ----------------------------------------------------------------------------
module wsi_fifo #(
	parameter int WIDTH = 34,
	parameter int DEPTH = 4
)(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             full,
	input  logic [WIDTH-1:0] wr_data,
	output logic             rd_valid,
	input  logic             rd_take,
	output logic [WIDTH-1:0] rd_data
);
	localparam int PTR_W = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             push;
	logic             pop;

	assign full     = count_q == (PTR_W+1)'(DEPTH);
	assign rd_valid = count_q != '0;
	assign push     = wr_valid && !full;
	assign pop      = rd_take && rd_valid;
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + (PTR_W+1)'(1);
				2'b01:   count_q <= count_q - (PTR_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (PTR_W+1)'(DEPTH))
		else $error("queue count beyond depth");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rd_take |-> rd_valid)
		else $error("take from empty queue");

endmodule
`default_nettype wire

[sv/wsi_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wsi_front
// Accepts count pairs, classifies the error cases and queues them; also holds
// the squared z register.
// ----------------------------------------------------------------------------
module wsi_front
	import wsi_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  item_t             item,
	input  logic              z_score_we,
	input  logic [Z_BITS-1:0] z_score_wdata,
	output logic [S_BITS-1:0] z_sq,
	output logic              entry_valid,
	input  logic              entry_pop,
	output entry_t            entry
);
	logic [S_BITS-1:0] z_sq_q;
	logic [S_BITS-1:0] z_sq_next;
	entry_t            cls;
	logic [$bits(entry_t)-1:0] rd_bits;

	assign z_sq_next = z_score_wdata * z_score_wdata;
	assign z_sq      = z_sq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			z_sq_q <= S_RESET;
		end else if (z_score_we) begin
			z_sq_q <= z_sq_next;
		end
	end

	always_comb begin
		cls.k = item.successes[COUNT_BITS-1:0];
		cls.n = item.trials[COUNT_BITS-1:0];
		priority if (cls.n == '0) begin
			cls.err = ERR_ZERO_TRIALS;
		end else if (cls.k > cls.n) begin
			cls.err = ERR_EXCESS;
		end else begin
			cls.err = ERR_OK;
		end
	end

	wsi_fifo #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (item_valid),
		.full     (item_stall),
		.wr_data  (cls),
		.rd_valid (entry_valid),
		.rd_take  (entry_pop),
		.rd_data  (rd_bits)
	);

	assign entry = entry_t'(rd_bits);

endmodule
`default_nettype wire

[sv/wsi_div_pipe.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wsi_div_pipe
// Pipelined restoring divider, one quotient bit per stage, with a tag that
// travels alongside. Needs num < den * 2^QUO_W.
// ----------------------------------------------------------------------------
module wsi_div_pipe #(
	parameter int NUM_W = 34,
	parameter int DEN_W = 17,
	parameter int QUO_W = 18,
	parameter int TAG_W = 2
)(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             launch,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	input  logic [TAG_W-1:0] tag,
	output logic             done,
	output logic [QUO_W-1:0] quo,
	output logic [TAG_W-1:0] done_tag
);
	logic [DEN_W-1:0] rem_q  [QUO_W];
	logic [QUO_W-1:0] work_q [QUO_W];
	logic [DEN_W-1:0] den_q  [QUO_W];
	logic [TAG_W-1:0] tag_q  [QUO_W];
	logic [QUO_W-1:0] vld_q;

	logic [DEN_W-1:0] rem_prev  [QUO_W];
	logic [QUO_W-1:0] work_prev [QUO_W];
	logic [DEN_W-1:0] den_prev  [QUO_W];
	logic [DEN_W:0]   trial     [QUO_W];
	logic [QUO_W-1:0] ge;

	always_comb begin
		rem_prev[0]  = DEN_W'(num >> QUO_W);
		work_prev[0] = num[QUO_W-1:0];
		den_prev[0]  = den;
		for (int i = 1; i < QUO_W; i++) begin
			rem_prev[i]  = rem_q[i-1];
			work_prev[i] = work_q[i-1];
			den_prev[i]  = den_q[i-1];
		end
		for (int i = 0; i < QUO_W; i++) begin
			trial[i] = {rem_prev[i], work_prev[i][QUO_W-1]};
			ge[i]    = trial[i] >= {1'b0, den_prev[i]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_q[0] <= tag;
			for (int i = 0; i < QUO_W; i++) begin
				rem_q[i]  <= ge[i] ? DEN_W'(trial[i] - {1'b0, den_prev[i]})
					: trial[i][DEN_W-1:0];
				work_q[i] <= {work_prev[i][QUO_W-2:0], ge[i]};
				den_q[i]  <= den_prev[i];
			end
			for (int i = 1; i < QUO_W; i++) begin
				tag_q[i] <= tag_q[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[QUO_W-2:0], launch};
		end
	end

	assign done     = vld_q[QUO_W-1];
	assign quo      = work_q[QUO_W-1];
	assign done_tag = tag_q[QUO_W-1];

endmodule
`default_nettype wire

[sv/wsi_sqrt_pipe.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wsi_sqrt_pipe
// Pipelined digit-by-digit integer square root, one root bit per stage,
// with a tag that travels alongside.
// ----------------------------------------------------------------------------
module wsi_sqrt_pipe #(
	parameter int ARG_W = 112,
	parameter int TAG_W = 34
)(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 launch,
	input  logic [ARG_W-1:0]     arg,
	input  logic [TAG_W-1:0]     tag,
	output logic                 done,
	output logic [ARG_W/2-1:0]   root,
	output logic [TAG_W-1:0]     done_tag
);
	localparam int ROOT_W = ARG_W / 2;
	localparam int REM_W  = ROOT_W + 2;

	logic [REM_W-1:0]  rem_q  [ROOT_W];
	logic [ROOT_W-1:0] x_q    [ROOT_W];
	logic [ARG_W-1:0]  a_q    [ROOT_W];
	logic [TAG_W-1:0]  tag_q  [ROOT_W];
	logic [ROOT_W-1:0] vld_q;

	logic [REM_W-1:0]  rem_prev [ROOT_W];
	logic [ROOT_W-1:0] x_prev   [ROOT_W];
	logic [ARG_W-1:0]  a_prev   [ROOT_W];
	logic [REM_W+1:0]  trial    [ROOT_W];
	logic [REM_W+1:0]  test     [ROOT_W];
	logic [ROOT_W-1:0] ge;

	always_comb begin
		rem_prev[0] = '0;
		x_prev[0]   = '0;
		a_prev[0]   = arg;
		for (int i = 1; i < ROOT_W; i++) begin
			rem_prev[i] = rem_q[i-1];
			x_prev[i]   = x_q[i-1];
			a_prev[i]   = a_q[i-1];
		end
		for (int i = 0; i < ROOT_W; i++) begin
			trial[i] = {rem_prev[i], a_prev[i][ARG_W-1 -: 2]};
			test[i]  = (REM_W+2)'({x_prev[i], 2'b01});
			ge[i]    = trial[i] >= test[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_q[0] <= tag;
			for (int i = 0; i < ROOT_W; i++) begin
				rem_q[i] <= ge[i] ? REM_W'(trial[i] - test[i]) : REM_W'(trial[i]);
				x_q[i]   <= {x_prev[i][ROOT_W-2:0], ge[i]};
				a_q[i]   <= {a_prev[i][ARG_W-3:0], 2'b00};
			end
			for (int i = 1; i < ROOT_W; i++) begin
				tag_q[i] <= tag_q[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[ROOT_W-2:0], launch};
		end
	end

	assign done     = vld_q[ROOT_W-1];
	assign root     = x_q[ROOT_W-1];
	assign done_tag = tag_q[ROOT_W-1];

endmodule
`default_nettype wire

[sv/wsi_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wsi_back
// Arithmetic pipeline: products, variance division, square root, and the
// three rounding divisions, ending in the result register.
// ----------------------------------------------------------------------------
module wsi_back
	import wsi_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              entry_valid,
	input  entry_t            entry,
	output logic              entry_pop,
	input  logic [S_BITS-1:0] z_sq,
	output logic              result_valid,
	input  logic              result_stall,
	output result_t           result
);
	typedef struct packed {
		logic [COUNT_BITS-1:0] k;
		logic [COUNT_BITS-1:0] n;
		err_t                  err;
		logic [P_BITS-1:0]     ss;
	} vtag_t;

	typedef struct packed {
		logic [COUNT_BITS-1:0] k;
		logic [COUNT_BITS-1:0] n;
		err_t                  err;
	} rtag_t;

	logic adv;

	// stage 1: k(n-k)
	logic                  valid_s1;
	logic [COUNT_BITS-1:0] k_s1, n_s1;
	err_t                  err_s1;
	logic [KK_BITS-1:0]    kk_s1;
	logic [KK_BITS-1:0]    kk_next;
	logic [COUNT_BITS-1:0] nk_diff;

	// stage 2: s*k(n-k) and s^2
	logic                  valid_s2;
	logic [COUNT_BITS-1:0] k_s2, n_s2;
	err_t                  err_s2;
	logic [P_BITS-1:0]     p_s2, ss_s2;
	logic [P_BITS-1:0]     p_next, ss_next;

	// variance division
	vtag_t                 vtag_in, vtag_out;
	logic                  vdiv_done;
	logic [VQ_BITS-1:0]    vq;

	// stage 3: V
	logic                  valid_s3;
	rtag_t                 rtag_s3;
	logic [V_BITS-1:0]     v_s3;

	// root
	rtag_t                 rtag_out;
	logic                  sq_done;
	logic [W_BITS-1:0]     w_root;

	// stages 4 to 6: numerators and denominators
	logic                  valid_s4, valid_s5, valid_s6;
	err_t                  err_s4, err_s5, err_s6;
	logic [CG_BITS-1:0]    cg_s4;
	logic [CD_BITS-1:0]    d_s4, d_s5;
	logic [W_BITS-1:0]     w_s4;
	logic [PNUM_BITS-1:0]  pnum_s4, pnum_s5, pnum_s6;
	logic [PDEN_BITS-1:0]  pden_s4, pden_s5, pden_s6;
	logic [CG_BITS-1:0]    lodiff_s5;
	logic [CG_BITS:0]      hisum_s5;
	logic [BNUM_BITS-1:0]  lonum_s6, hinum_s6;
	logic [BDEN_BITS-1:0]  bden_s6;
	logic [CD_BITS-1:0]    c_next;

	// final divisions
	logic                  fdiv_done;
	err_t                  ferr;
	logic [$bits(err_t)-1:0] ferr_bits;
	logic [Q_BITS-1:0]     lq, hq, pq;

	result_t               result_q;
	logic                  result_valid_q;
	result_t               res_next;

	assign adv       = !result_valid_q || !result_stall;
	assign entry_pop = adv && entry_valid;

	assign nk_diff = entry.n - entry.k;
	assign kk_next = entry.k * nk_diff;
	assign p_next  = z_sq * kk_s1;
	assign ss_next = z_sq * z_sq;
	assign c_next  = (CD_BITS'(rtag_out.k) << CD_SHIFT) + CD_BITS'(z_sq);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			valid_s2       <= 1'b0;
			valid_s3       <= 1'b0;
			valid_s4       <= 1'b0;
			valid_s5       <= 1'b0;
			valid_s6       <= 1'b0;
			result_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1       <= entry_valid;
			valid_s2       <= valid_s1;
			valid_s3       <= vdiv_done;
			valid_s4       <= sq_done;
			valid_s5       <= valid_s4;
			valid_s6       <= valid_s5;
			result_valid_q <= fdiv_done;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			k_s1     <= entry.k;
			n_s1     <= entry.n;
			err_s1   <= entry.err;
			kk_s1    <= kk_next;

			k_s2     <= k_s1;
			n_s2     <= n_s1;
			err_s2   <= err_s1;
			p_s2     <= p_next;
			ss_s2    <= ss_next;

			rtag_s3.k   <= vtag_out.k;
			rtag_s3.n   <= vtag_out.n;
			rtag_s3.err <= vtag_out.err;
			v_s3        <= V_BITS'(vq) + V_BITS'(vtag_out.ss);

			cg_s4    <= CG_BITS'(c_next) << GUARD;
			d_s4     <= (CD_BITS'(rtag_out.n) << CD_SHIFT) + (CD_BITS'(z_sq) << 1);
			w_s4     <= w_root;
			err_s4   <= rtag_out.err;
			pnum_s4  <= (PNUM_BITS'(rtag_out.k) << (FRAC_BITS + 1)) + PNUM_BITS'(rtag_out.n);
			pden_s4  <= PDEN_BITS'(rtag_out.n) << 1;

			// low end clamps at zero when the half width reaches the centre
			lodiff_s5 <= (CG_BITS'(w_s4) < cg_s4) ? cg_s4 - CG_BITS'(w_s4) : '0;
			hisum_s5  <= (CG_BITS+1)'(cg_s4) + (CG_BITS+1)'(w_s4);
			d_s5      <= d_s4;
			err_s5    <= err_s4;
			pnum_s5   <= pnum_s4;
			pden_s5   <= pden_s4;

			lonum_s6  <= BNUM_BITS'(lodiff_s5) + BNUM_BITS'(d_s5);
			hinum_s6  <= BNUM_BITS'(hisum_s5) + BNUM_BITS'(d_s5);
			bden_s6   <= BDEN_BITS'(d_s5) << 1;
			err_s6    <= err_s5;
			pnum_s6   <= pnum_s5;
			pden_s6   <= pden_s5;

			result_q  <= res_next;
		end
	end

	always_comb begin
		vtag_in.k   = k_s2;
		vtag_in.n   = n_s2;
		vtag_in.err = err_s2;
		vtag_in.ss  = ss_s2;
	end

	wsi_div_pipe #(
		.NUM_W (VNUM_BITS),
		.DEN_W (COUNT_BITS),
		.QUO_W (VQ_BITS),
		.TAG_W ($bits(vtag_t))
	) u_vdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.launch   (valid_s2),
		.num      ({p_s2, {V_SHIFT{1'b0}}}),
		.den      (n_s2),
		.tag      (vtag_in),
		.done     (vdiv_done),
		.quo      (vq),
		.done_tag (vtag_out)
	);

	wsi_sqrt_pipe #(
		.ARG_W (SQ_ARG_BITS),
		.TAG_W ($bits(rtag_t))
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.launch   (valid_s3),
		.arg      (SQ_ARG_BITS'(v_s3) << (2 * GUARD)),
		.tag      (rtag_s3),
		.done     (sq_done),
		.root     (w_root),
		.done_tag (rtag_out)
	);

	wsi_div_pipe #(
		.NUM_W (BNUM_BITS),
		.DEN_W (BDEN_BITS),
		.QUO_W (Q_BITS),
		.TAG_W ($bits(err_t))
	) u_lodiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.launch   (valid_s6),
		.num      (lonum_s6),
		.den      (bden_s6),
		.tag      (err_s6),
		.done     (fdiv_done),
		.quo      (lq),
		.done_tag (ferr_bits)
	);

	assign ferr = err_t'(ferr_bits);

	wsi_div_pipe #(
		.NUM_W (BNUM_BITS),
		.DEN_W (BDEN_BITS),
		.QUO_W (Q_BITS),
		.TAG_W (1)
	) u_hidiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.launch   (valid_s6),
		.num      (hinum_s6),
		.den      (bden_s6),
		.tag      (1'b0),
		.done     (),
		.quo      (hq),
		.done_tag ()
	);

	wsi_div_pipe #(
		.NUM_W (PNUM_BITS),
		.DEN_W (PDEN_BITS),
		.QUO_W (Q_BITS),
		.TAG_W (1)
	) u_pdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.launch   (valid_s6),
		.num      (pnum_s6),
		.den      (pden_s6),
		.tag      (1'b0),
		.done     (),
		.quo      (pq),
		.done_tag ()
	);

	always_comb begin
		res_next            = '0;
		res_next.error_code = ferr;
		if (ferr == ERR_OK) begin
			res_next.proportion  = pq[OUT_BITS-1:0];
			res_next.lower_bound = lq[OUT_BITS-1:0];
			res_next.upper_bound = (hq > Q_BITS'(ONE)) ? ONE : hq[OUT_BITS-1:0];
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && (result_q.error_code != ERR_OK) |->
		(result_q.proportion == '0) && (result_q.lower_bound == '0) &&
		(result_q.upper_bound == '0))
		else $error("error transaction with nonzero values");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && (result_q.error_code == ERR_OK) |->
		result_q.lower_bound <= result_q.upper_bound)
		else $error("interval bounds out of order");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> (result_q.upper_bound <= ONE) && (result_q.proportion <= ONE))
		else $error("value above one");

endmodule
`default_nettype wire
